// File: rtl/core/b64d_pkg.sv
// shared types, status codes and alphabet lookup for the base64url decoder
package b64d_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;
    localparam logic [1:0] STATUS_LEFTOVER = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       run_end;
        logic [1:0] status;
    } out_word_t;

    // classified character handed from front to back
    typedef struct packed {
        logic [5:0] sextet;
        logic       in_alphabet;
        logic       has_char;
        logic       last;
    } cls_word_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        r.hit   = 1'b1;
        r.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2d) begin
            r.value = 6'd62;
        end else if (c == 8'h5f) begin
            r.value = 6'd63;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/b64d_front.sv
// input stage: accepts characters and classifies them against the alphabet
module b64d_front
    import b64d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      push,
    input  logic      push_ready,
    output cls_word_t push_word
);

    logic      vld_reg;
    logic      vld_next;
    cls_word_t word_reg;
    sextet_t   lookup;

    assign lookup  = sextet_of(s_data.char_code);
    assign s_ready = !vld_reg || push_ready;
    assign push    = vld_reg;
    assign push_word = word_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end else if (push_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg.sextet      <= lookup.value;
            word_reg.in_alphabet <= lookup.hit;
            word_reg.has_char    <= s_data.has_char;
            word_reg.last        <= s_data.end_of_text;
        end
    end

endmodule

// File: rtl/core/b64d_queue.sv
// short queue of classified characters between front and back
module b64d_queue
    import b64d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    output logic      push_ready,
    input  cls_word_t push_word,
    output logic      pop_valid,
    input  logic      pop,
    output cls_word_t pop_word
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    cls_word_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: rtl/core/b64d_back.sv
// decode stage: bit accumulator, byte emission, run-end status and output register
module b64d_back
    import b64d_pkg::*;
#(
    parameter int unsigned MAX_CHARS = 512
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop,
    input  cls_word_t pop_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int unsigned CNTW = $clog2(MAX_CHARS + 2);
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_CHARS);

    logic [11:0]     acc_reg;
    logic [11:0]     acc_next;
    logic [3:0]      pend_reg;
    logic [3:0]      pend_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            bad_reg;
    logic            bad_next;
    logic            out_vld_reg;
    logic            out_vld_next;
    out_word_t       out_reg;
    out_word_t       out_next;
    logic [11:0]     acc_shift;
    logic [11:0]     left_mask;
    logic [3:0]      pend_add;

    assign pop     = pop_valid && (!out_vld_reg || m_ready);
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_comb begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        bad_next  = bad_reg;
        out_next  = '0;
        acc_shift = '0;
        left_mask = '0;
        pend_add  = pend_reg + 4'd6;
        if (pop_word.has_char) begin
            if (cnt_reg <= MAX_CNT) begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (!bad_reg) begin
                if (!pop_word.in_alphabet) begin
                    bad_next = 1'b1;
                end else begin
                    acc_next  = {acc_reg[5:0], pop_word.sextet};
                    pend_next = pend_add;
                    if (pend_add >= 4'd8) begin
                        pend_next           = pend_add - 4'd8;
                        acc_shift           = acc_next >> pend_next;
                        out_next.data_byte  = acc_shift[7:0];
                        out_next.byte_valid = 1'b1;
                    end
                end
            end
        end
        if (pop_word.last) begin
            out_next.run_end = 1'b1;
            left_mask = (12'd1 << pend_next) - 12'd1;
            if (cnt_next == '0 || cnt_next > MAX_CNT || cnt_next[1:0] == 2'd1) begin
                out_next.status = STATUS_BAD_LEN;
            end else if (bad_next) begin
                out_next.status = STATUS_BAD_CHAR;
            end else if ((acc_next & left_mask) != '0) begin
                out_next.status = STATUS_LEFTOVER;
            end else begin
                out_next.status = STATUS_OK;
            end
            acc_next  = '0;
            pend_next = '0;
            cnt_next  = '0;
            bad_next  = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (pop) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            pend_reg    <= '0;
            cnt_reg     <= '0;
            bad_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            if (pop) begin
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
                cnt_reg  <= cnt_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/core/base64url_decoder_checked_core.sv
// top level of the unpadded base64url decoder with run-end status
// One word per cycle in each direction while the output is not stalled: every
// input word yields exactly one result word, registered in turn in the front
// classify register, one slot of the four-entry queue, then the decode output
// register. The queue lets the front keep taking words while a result waits.
// A result carries a byte when the character completed eight bits, and the
// word marked end_of_text carries the run status (bad length, bad character,
// nonzero leftover bits, in that order); a run whose status is not ok is to
// be discarded. MAX_CHARS sets the longest accepted run.
module base64url_decoder_checked_core
    import b64d_pkg::*;
#(
    parameter int unsigned MAX_CHARS = 512
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      push;
    logic      push_ready;
    cls_word_t push_word;
    logic      pop_valid;
    logic      pop;
    cls_word_t pop_word;

    b64d_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    b64d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_word   (pop_word)
    );

    b64d_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_word  (pop_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: rtl/core/b64d_checker.sv
// port-level checks for the base64url decoder, bound to the top level
module b64d_checker
    import b64d_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.run_end |-> m_data.status == STATUS_OK)
        else $error("status outside run end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.data_byte == 8'd0)
        else $error("data without byte");

endmodule

bind base64url_decoder_checked_core b64d_checker u_b64d_checker (.*);
